// ----- rtl/adaptive_speedup_controller_core_macros.svh -----
// Assertion macros used by the checker file of the speedup controller.
`ifndef ADAPTIVE_SPEEDUP_CONTROLLER_CORE_MACROS_SVH
`define ADAPTIVE_SPEEDUP_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/asc_pkg.sv -----
package asc_pkg;

    localparam int MODEL_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 32;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 72;

    typedef logic signed [47:0] fx_t;

    localparam fx_t FX_MAX = {1'b0, {47{1'b1}}};
    localparam fx_t FX_MIN = {1'b1, 47'b0};
    localparam logic [49:0] LIM_POS = {3'b000, {47{1'b1}}};
    localparam logic [49:0] LIM_NEG = {3'b001, 47'b0};

    // Item kinds carried in tuser.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_MEAS    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Schedule selection.
    localparam logic [1:0] STRAT_MIN      = 2'd0;
    localparam logic [1:0] STRAT_NEIGHBOR = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_STRAT  = 3'd2;
    localparam logic [2:0] REG_START  = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_ADD  = 3'd0;
    localparam alu_op_t ALU_SUB  = 3'd1;
    localparam alu_op_t ALU_MUL  = 3'd2;
    localparam alu_op_t ALU_DIV  = 3'd3;
    localparam alu_op_t ALU_IDIV = 3'd4;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        fx_t         a;
        fx_t         b;
        logic [15:0] n;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        fx_t         res;
        logic        big16;
        logic [15:0] low16;
    } alu_rsp_t;

    function automatic logic [47:0] fx_mag(fx_t a);
        return a[47] ? (~a + 48'd1) : a;
    endfunction

    // Signs a magnitude and saturates it to the 48-bit range.
    function automatic fx_t fx_pack(logic neg, logic big, logic [49:0] mag);
        logic [47:0] m48;
        m48 = mag[47:0];
        if (neg) begin
            if (big || mag > LIM_NEG) return FX_MIN;
            return fx_t'(~m48 + 48'd1);
        end
        if (big || mag > LIM_POS) return FX_MAX;
        return fx_t'(m48);
    endfunction

    function automatic fx_t fx_add(fx_t a, fx_t b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) return s[48] ? FX_MIN : FX_MAX;
        return fx_t'(s[47:0]);
    endfunction

    function automatic fx_t fx_sub(fx_t a, fx_t b);
        logic signed [48:0] s;
        s = {a[47], a} - {b[47], b};
        if (s[48] != s[47]) return s[48] ? FX_MIN : FX_MAX;
        return fx_t'(s[47:0]);
    endfunction

endpackage

// ----- rtl/adaptive_speedup_controller_core.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser operation; s_tdata entry and measurement fields
// m_        out  m_tvalid/m_tready  m_tdata lower/upper entry, iterations, speedup
// apb       in   psel/penable       five configuration registers at 8*i
//
// A load is written from the idle state; a restart passes through ST_RS_B. A measurement runs
// the filter update as a microsequence through one shared unit, which forms a product from
// partial products and a quotient by restoring division (one quotient bit per cycle). The
// neighbor heuristic scans the entries and works out one pair; the cost searches work out
// each admissible pair.
// Reset is synchronous and active low; while a result waits on m_tready the next item
// is still taken, and a finished measurement holds until the output register is free.
module adaptive_speedup_controller_core import asc_pkg::*; #(
    parameter int MODEL_DEPTH   = MODEL_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, entry_speedup, entry_cost, measurement, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // lower_entry, upper_entry, lower_iterations, speedup_now, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int IDX_W = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;
    localparam longint ONE_L = longint'(1) << FRACTION_BITS;
    localparam fx_t K_ONE = fx_t'(ONE_L);
    localparam fx_t K_X0  = fx_t'((ONE_L + 2) / 5);
    localparam fx_t K_QN  = fx_t'((ONE_L + 50000) / 100000);
    localparam fx_t K_RN  = fx_t'((ONE_L + 50) / 100);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RS_B   = 4'd1;
    localparam logic [3:0] ST_ISSUE  = 4'd2;
    localparam logic [3:0] ST_WAIT   = 4'd3;
    localparam logic [3:0] ST_LAST_A = 4'd4;
    localparam logic [3:0] ST_LAST_B = 4'd5;
    localparam logic [3:0] ST_SCAN_I = 4'd6;
    localparam logic [3:0] ST_RDU_A  = 4'd7;
    localparam logic [3:0] ST_RDU_B  = 4'd8;
    localparam logic [3:0] ST_SCAN_J = 4'd9;
    localparam logic [3:0] ST_RDL_A  = 4'd10;
    localparam logic [3:0] ST_RDL_B  = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    // Filter update steps.
    localparam logic [4:0] MS_PRED_COV = 5'd0;
    localparam logic [4:0] MS_PH       = 5'd1;
    localparam logic [4:0] MS_HPH      = 5'd2;
    localparam logic [4:0] MS_SDEN     = 5'd3;
    localparam logic [4:0] MS_GAIN     = 5'd4;
    localparam logic [4:0] MS_HX       = 5'd5;
    localparam logic [4:0] MS_INNOV    = 5'd6;
    localparam logic [4:0] MS_KINN     = 5'd7;
    localparam logic [4:0] MS_EST      = 5'd8;
    localparam logic [4:0] MS_KH       = 5'd9;
    localparam logic [4:0] MS_ONE_KH   = 5'd10;
    localparam logic [4:0] MS_COV      = 5'd11;
    localparam logic [4:0] MS_INV_EST  = 5'd12;
    localparam logic [4:0] MS_ERR      = 5'd13;
    localparam logic [4:0] MS_CORR     = 5'd14;
    localparam logic [4:0] MS_SPEED    = 5'd15;
    // Pair schedule steps.
    localparam logic [4:0] PS_UL       = 5'd16;
    localparam logic [4:0] PS_TL       = 5'd17;
    localparam logic [4:0] PS_NUM      = 5'd18;
    localparam logic [4:0] PS_UT       = 5'd19;
    localparam logic [4:0] PS_DEN      = 5'd20;
    localparam logic [4:0] PS_FRAC     = 5'd21;
    localparam logic [4:0] PS_ITERS    = 5'd22;
    localparam logic [4:0] PS_LOW_T    = 5'd23;
    localparam logic [4:0] PS_LOW_C    = 5'd24;
    localparam logic [4:0] PS_UP_T     = 5'd25;
    localparam logic [4:0] PS_UP_C     = 5'd26;
    localparam logic [4:0] PS_COST     = 5'd27;

    logic [94:0] mem [MODEL_DEPTH];
    logic [94:0] rd_q;
    logic [IDX_W-1:0] ra_c;

    fx_t         tc_reg;
    logic [15:0] wl_reg;
    logic [1:0]  strat_reg;
    logic [3:0]  start_reg;
    logic [4:0]  ecnt_reg;

    logic [3:0]  state_reg;
    logic [4:0]  step_reg;
    logic [4:0]  i_reg, j_reg, lower_reg, upper_reg;
    logic        found_reg;
    fx_t         best_reg;
    logic [15:0] n_reg, iters_reg;
    fx_t         we_reg, p_reg, cs_reg, meas_reg, pm_reg, k_reg;
    fx_t         ta_reg, tb_reg, tu_reg;
    fx_t         us_reg, uc_reg, ls_reg, lc_reg;

    logic        m_tvalid_reg;
    logic [3:0]  out_lower_reg, out_upper_reg;
    logic [15:0] out_iters_reg;
    logic [46:0] out_spd_reg;

    alu_req_t    req;
    alu_rsp_t    rsp;

    logic [4:0]  cnt_c, start_c;
    logic        s_acc, cfg_wr, heur_c, maxim_c;
    fx_t         rd_spd, rd_cost, u_c, clamp_c;
    logic [15:0] n_iter_c;

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign heur_c  = strat_reg == STRAT_NEIGHBOR;
    assign maxim_c = strat_reg != STRAT_MIN;
    assign rd_spd  = fx_t'({1'b0, rd_q[46:0]});
    assign rd_cost = fx_t'(rd_q[94:47]);

    always_comb begin
        cnt_c = ecnt_reg;
        if (ecnt_reg == 5'd0) cnt_c = 5'd1;
        else if (32'(ecnt_reg) > MODEL_DEPTH) cnt_c = 5'(MODEL_DEPTH);
        start_c = ({1'b0, start_reg} < cnt_c) ? {1'b0, start_reg} : 5'(cnt_c - 5'd1);
    end

    // Read address for the next cycle's registered memory output.
    always_comb begin
        unique case (state_reg)
            ST_IDLE:   ra_c = IDX_W'(start_c);
            ST_LAST_A: ra_c = IDX_W'(5'(cnt_c - 5'd1));
            ST_RDU_A:  ra_c = IDX_W'(i_reg);
            ST_RDL_A:  ra_c = IDX_W'(j_reg);
            default:   ra_c = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == OP_LOAD && 32'(s_tdata[3:0]) < MODEL_DEPTH) begin
            mem[IDX_W'(s_tdata[3:0])] <= {s_tdata[98:51], s_tdata[50:4]};
        end
        rd_q <= mem[ra_c];
    end

    // Operand selection for the shared arithmetic unit.
    always_comb begin
        req.start = state_reg == ST_ISSUE;
        req.op    = ALU_MUL;
        req.a     = ta_reg;
        req.b     = tb_reg;
        req.n     = n_reg;
        unique case (step_reg)
            MS_PRED_COV: begin req.op = ALU_ADD; req.a = p_reg;    req.b = K_QN;     end
            MS_PH:       begin req.a = pm_reg;   req.b = cs_reg;                     end
            MS_HPH:      begin req.a = ta_reg;   req.b = cs_reg;                     end
            MS_SDEN:     begin req.op = ALU_ADD; req.a = tb_reg;   req.b = K_RN;     end
            MS_GAIN:     begin req.op = ALU_DIV;                                     end
            MS_HX:       begin req.a = cs_reg;   req.b = we_reg;                     end
            MS_INNOV:    begin req.op = ALU_SUB; req.a = meas_reg; req.b = ta_reg;   end
            MS_KINN:     begin req.a = k_reg;    req.b = ta_reg;                     end
            MS_EST:      begin req.op = ALU_ADD; req.a = we_reg;   req.b = ta_reg;   end
            MS_KH:       begin req.a = k_reg;    req.b = cs_reg;                     end
            MS_ONE_KH:   begin req.op = ALU_SUB; req.a = K_ONE;    req.b = ta_reg;   end
            MS_COV:      begin req.a = ta_reg;   req.b = pm_reg;                     end
            MS_INV_EST:  begin req.op = ALU_DIV; req.a = K_ONE;    req.b = we_reg;   end
            MS_ERR:      begin req.op = ALU_SUB; req.a = tc_reg;   req.b = meas_reg; end
            MS_CORR:     begin req.a = ta_reg;   req.b = tb_reg;                     end
            MS_SPEED:    begin req.op = ALU_ADD; req.a = cs_reg;   req.b = ta_reg;   end
            PS_UL:       begin req.a = us_reg;   req.b = ls_reg;                     end
            PS_TL:       begin req.a = cs_reg;   req.b = ls_reg;                     end
            PS_NUM:      begin req.op = ALU_SUB;                                     end
            PS_UT:       begin req.a = us_reg;   req.b = cs_reg;                     end
            PS_DEN:      begin req.op = ALU_SUB; req.a = tu_reg;                     end
            PS_FRAC:     begin req.op = ALU_DIV;                                     end
            PS_ITERS:    begin req.a = fx_t'({32'b0, wl_reg}); req.b = ta_reg;       end
            PS_LOW_T:    begin req.op = ALU_IDIV; req.b = ls_reg;                    end
            PS_LOW_C:    begin req.a = ta_reg;   req.b = lc_reg;                     end
            PS_UP_T:     begin req.op = ALU_IDIV; req.b = us_reg;
                               req.n = wl_reg - n_reg;                               end
            PS_UP_C:     begin req.a = tb_reg;   req.b = uc_reg;                     end
            PS_COST:     begin req.op = ALU_ADD;                                     end
            default:     begin req.op = ALU_ADD;                                     end
        endcase
    end

    asc_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        n_iter_c = (rsp.big16 || rsp.low16 > wl_reg) ? wl_reg : rsp.low16;
        // The floor of one applies first, the last entry's speedup has the final word.
        u_c      = (ta_reg < K_ONE) ? K_ONE : ta_reg;
        clamp_c  = (u_c > rd_spd) ? rd_spd : u_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg       <= '0;
            wl_reg       <= 16'd1;
            strat_reg    <= STRAT_NEIGHBOR;
            start_reg    <= '0;
            ecnt_reg     <= 5'd1;
            state_reg    <= ST_IDLE;
            step_reg     <= MS_PRED_COV;
            we_reg       <= K_X0;
            p_reg        <= K_ONE;
            cs_reg       <= K_ONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[5:3])
                    REG_TARGET: tc_reg    <= fx_t'(pwdata[47:0]);
                    REG_WINDOW: wl_reg    <= pwdata[15:0];
                    REG_STRAT:  strat_reg <= pwdata[1:0];
                    REG_START:  start_reg <= pwdata[3:0];
                    REG_COUNT:  ecnt_reg  <= pwdata[4:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_tuser == OP_MEAS) begin
                        meas_reg  <= fx_t'(s_tdata[146:99]);
                        step_reg  <= MS_PRED_COV;
                        state_reg <= ST_ISSUE;
                    end else if (s_acc && s_tuser == OP_RESTART) begin
                        state_reg <= ST_RS_B;
                    end
                end
                ST_RS_B: begin
                    we_reg    <= K_X0;
                    p_reg     <= K_ONE;
                    cs_reg    <= rd_spd;
                    state_reg <= ST_IDLE;
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (rsp.done) begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= ST_ISSUE;
                        unique case (step_reg)
                            MS_PRED_COV: pm_reg <= rsp.res;
                            MS_GAIN:     k_reg  <= rsp.res;
                            MS_EST:      we_reg <= rsp.res;
                            MS_COV:      p_reg  <= rsp.res;
                            MS_HPH, MS_SDEN, MS_ERR, PS_TL, PS_DEN, PS_UP_T, PS_UP_C:
                                tb_reg <= rsp.res;
                            PS_UT:       tu_reg <= rsp.res;
                            MS_SPEED: begin
                                ta_reg    <= rsp.res;
                                state_reg <= ST_LAST_A;
                            end
                            PS_FRAC: begin
                                ta_reg <= rsp.res;
                                if (rsp.res[47] || rsp.res == '0) begin
                                    n_reg <= '0;
                                    if (heur_c) begin
                                        iters_reg <= '0;
                                        state_reg <= ST_EMIT;
                                    end else begin
                                        step_reg <= PS_LOW_T;
                                    end
                                end
                            end
                            PS_ITERS: begin
                                n_reg <= n_iter_c;
                                if (heur_c) begin
                                    iters_reg <= n_iter_c;
                                    state_reg <= ST_EMIT;
                                end
                            end
                            PS_COST: begin
                                if (!found_reg || (maxim_c ? rsp.res > best_reg
                                                           : rsp.res < best_reg)) begin
                                    found_reg <= 1'b1;
                                    best_reg  <= rsp.res;
                                    upper_reg <= i_reg;
                                    lower_reg <= j_reg;
                                    iters_reg <= n_reg;
                                end
                                j_reg     <= j_reg + 5'd1;
                                state_reg <= ST_SCAN_J;
                            end
                            default: ta_reg <= rsp.res;
                        endcase
                    end
                end
                ST_LAST_A: state_reg <= ST_LAST_B;
                ST_LAST_B: begin
                    cs_reg    <= clamp_c;
                    i_reg     <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    lower_reg <= '0;
                    upper_reg <= '0;
                    iters_reg <= '0;
                    state_reg <= ST_SCAN_I;
                end
                ST_SCAN_I: state_reg <= (i_reg == cnt_c) ? ST_EMIT : ST_RDU_A;
                ST_RDU_A:  state_reg <= ST_RDU_B;
                ST_RDU_B: begin
                    us_reg <= rd_spd;
                    uc_reg <= rd_cost;
                    if (rd_spd < cs_reg) begin
                        i_reg     <= i_reg + 5'd1;
                        state_reg <= ST_SCAN_I;
                    end else if (heur_c) begin
                        upper_reg <= i_reg;
                        if (i_reg == 5'd0) begin
                            lower_reg <= '0;
                            iters_reg <= '0;
                            state_reg <= ST_EMIT;
                        end else begin
                            lower_reg <= i_reg - 5'd1;
                            j_reg     <= i_reg - 5'd1;
                            state_reg <= ST_RDL_A;
                        end
                    end else begin
                        j_reg     <= '0;
                        state_reg <= ST_SCAN_J;
                    end
                end
                ST_SCAN_J: begin
                    if (j_reg == cnt_c) begin
                        i_reg     <= i_reg + 5'd1;
                        state_reg <= ST_SCAN_I;
                    end else begin
                        state_reg <= ST_RDL_A;
                    end
                end
                ST_RDL_A: state_reg <= ST_RDL_B;
                ST_RDL_B: begin
                    ls_reg <= rd_spd;
                    lc_reg <= rd_cost;
                    if (!heur_c && rd_spd > cs_reg) begin
                        j_reg     <= j_reg + 5'd1;
                        state_reg <= ST_SCAN_J;
                    end else if (rd_spd == us_reg) begin
                        // Equal speedups leave nothing to split.
                        n_reg <= '0;
                        if (heur_c) begin
                            iters_reg <= '0;
                            state_reg <= ST_EMIT;
                        end else begin
                            step_reg  <= PS_LOW_T;
                            state_reg <= ST_ISSUE;
                        end
                    end else begin
                        step_reg  <= PS_UL;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        out_lower_reg <= lower_reg[3:0];
                        out_upper_reg <= upper_reg[3:0];
                        out_iters_reg <= iters_reg;
                        out_spd_reg   <= cs_reg[46:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_TARGET: prdata = 64'(tc_reg);
            REG_WINDOW: prdata = 64'(wl_reg);
            REG_STRAT:  prdata = 64'(strat_reg);
            REG_START:  prdata = 64'(start_reg);
            REG_COUNT:  prdata = 64'(ecnt_reg);
            default:    prdata = '0;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_spd_reg, out_iters_reg, out_upper_reg, out_lower_reg};

endmodule

// ----- rtl/asc_alu.sv -----
module asc_alu import asc_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int NUM_W = (48 + FRACTION_BITS > 16 + 2 * FRACTION_BITS) ?
                           48 + FRACTION_BITS : 16 + 2 * FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [95:0] HALF = 96'd1 << (FRACTION_BITS - 1);

    localparam logic [2:0] AM_IDLE = 3'd0;
    localparam logic [2:0] AM_MUL  = 3'd1;
    localparam logic [2:0] AM_MEND = 3'd2;
    localparam logic [2:0] AM_DIV  = 3'd3;
    localparam logic [2:0] AM_DEND = 3'd4;

    logic [2:0]       mode_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [47:0]      ma_reg, mb_reg, rem_reg;
    logic             neg_reg, ovf_reg;
    logic [95:0]      acc_reg;
    logic [NUM_W-1:0] num_reg;
    logic [48:0]      quo_reg;
    logic             done_reg, big16_reg;
    fx_t              res_reg;
    logic [15:0]      low16_reg;

    logic [23:0] a_half, b_half;
    logic [47:0] pp;
    logic [95:0] pp_sh, rnd;
    logic [48:0] r2;
    logic        ge, rup;
    logic [47:0] rem_next;
    logic [49:0] quo_rnd;

    // One 24x24 partial product per cycle, lowest first.
    always_comb begin
        a_half = cnt_reg[1] ? ma_reg[47:24] : ma_reg[23:0];
        b_half = cnt_reg[0] ? mb_reg[47:24] : mb_reg[23:0];
        pp     = a_half * b_half;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = 96'(pp);
            2'd3:    pp_sh = 96'(pp) << 48;
            default: pp_sh = 96'(pp) << 24;
        endcase
        rnd = (acc_reg + HALF) >> FRACTION_BITS;
    end

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        r2       = {rem_reg, num_reg[NUM_W-1]};
        ge       = r2 >= {1'b0, mb_reg};
        rem_next = ge ? 48'(r2 - {1'b0, mb_reg}) : r2[47:0];
        rup      = {rem_reg, 1'b0} >= {1'b0, mb_reg};
        quo_rnd  = 50'(quo_reg) + 50'(rup);
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            mode_reg <= AM_IDLE;
        end else begin
            unique case (mode_reg)
                AM_IDLE: begin
                    if (req.start) begin
                        cnt_reg <= '0;
                        neg_reg <= req.a[47] ^ req.b[47];
                        mb_reg  <= fx_mag(req.b);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        ovf_reg <= 1'b0;
                        unique case (req.op)
                            ALU_ADD: begin
                                res_reg  <= fx_add(req.a, req.b);
                                done_reg <= 1'b1;
                            end
                            ALU_SUB: begin
                                res_reg  <= fx_sub(req.a, req.b);
                                done_reg <= 1'b1;
                            end
                            ALU_MUL: begin
                                ma_reg   <= fx_mag(req.a);
                                acc_reg  <= '0;
                                mode_reg <= AM_MUL;
                            end
                            ALU_DIV: begin
                                if (req.b == '0) begin
                                    res_reg  <= req.a[47] ? FX_MIN : FX_MAX;
                                    done_reg <= 1'b1;
                                end else begin
                                    num_reg  <= NUM_W'(fx_mag(req.a)) << FRACTION_BITS;
                                    mode_reg <= AM_DIV;
                                end
                            end
                            ALU_IDIV: begin
                                if (req.b == '0) begin
                                    res_reg  <= FX_MAX;
                                    done_reg <= 1'b1;
                                end else begin
                                    num_reg  <= NUM_W'(req.n) << (2 * FRACTION_BITS);
                                    neg_reg  <= req.b[47];
                                    mode_reg <= AM_DIV;
                                end
                            end
                            default: begin
                                res_reg  <= '0;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                AM_MUL: begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(3)) mode_reg <= AM_MEND;
                end
                AM_MEND: begin
                    res_reg   <= fx_pack(neg_reg, |rnd[95:50], rnd[49:0]);
                    big16_reg <= |rnd[95:16];
                    low16_reg <= rnd[15:0];
                    done_reg  <= 1'b1;
                    mode_reg  <= AM_IDLE;
                end
                AM_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[47:0], ge};
                    ovf_reg <= ovf_reg | quo_reg[48];
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W - 1)) mode_reg <= AM_DEND;
                end
                AM_DEND: begin
                    res_reg  <= fx_pack(neg_reg, ovf_reg, quo_rnd);
                    done_reg <= 1'b1;
                    mode_reg <= AM_IDLE;
                end
                default: mode_reg <= AM_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.res   = res_reg;
    assign rsp.big16 = big16_reg;
    assign rsp.low16 = low16_reg;

endmodule

// ----- rtl/asc_checker.sv -----
`include "adaptive_speedup_controller_core_macros.svh"

module asc_checker import asc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 pready
);

    `ASC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ASC_ASSERT_SAME(a_pready, 1'b1, pready, "pready dropped")
    `ASC_ASSERT_NEXT(a_busy, s_tvalid && s_tready && (s_tuser == OP_MEAS || s_tuser == OP_RESTART), !s_tready, "input taken while an item is in work")
    `ASC_ASSERT_NEXT(a_no_early, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared one cycle after a transfer")

endmodule

bind adaptive_speedup_controller_core asc_checker u_asc_checker (.*);
